>>> sv/nsdp_pkg.sv
// Shared types and constants for the nearest-seed dot-product search.
package nsdp_pkg;

  localparam int SEED_DEPTH_DEF = 64;
  localparam int GROUP_LIMIT    = 64;

  localparam int COMP_W  = 16;
  localparam int IDX_W   = 6;
  localparam int GRP_W   = 6;
  localparam int CNT_W   = 7;
  localparam int PROD_W  = 2 * COMP_W;
  localparam int DOT_W   = PROD_W + 3;
  // wide enough to compare counts and indexes against any legal depth
  localparam int WIDE_W  = 13;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] z;
  } vec_t;

  typedef struct packed {
    vec_t             dir;
    logic [GRP_W-1:0] grp;
  } seed_t;

  // tags riding along with each entry through the scan pipeline
  typedef struct packed {
    logic live;
    logic last;
  } scan_ctl_t;

endpackage

>>> sv/nearest_seed_by_dot_product_core.sv
// Top level: seed ring, scan sequencer and result register.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i / in_stall_o | command, entry_index, dir_x/y/z, group_tag
//  out     | output    | out_valid_o / out_stall_i | seed_index, group_index, valid_res
//  cfg     | input     | cfg_we_i                | cfg_wdata_i (seed_count)
//
// A write does not leave the idle state, so the input stays ready for the next command.
// A query rotates the whole seed ring once, one entry into the dot-product pipeline
// per cycle, then drains the pipeline and loads the result register once the output
// can take it; the whole ring is rotated regardless of seed_count.
// Reset clears control state and seed_count; seed entries hold garbage until written.
// The input stalls while a query is in flight; writes go ahead while a result waits.
module nearest_seed_by_dot_product_core #(
  parameter int SEED_DEPTH = nsdp_pkg::SEED_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [nsdp_pkg::CNT_W-1:0]       cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             command_i,
  input  logic [nsdp_pkg::IDX_W-1:0]       entry_index_i,
  input  logic signed [nsdp_pkg::COMP_W-1:0] dir_x_i,
  input  logic signed [nsdp_pkg::COMP_W-1:0] dir_y_i,
  input  logic signed [nsdp_pkg::COMP_W-1:0] dir_z_i,
  input  logic [nsdp_pkg::GRP_W-1:0]       group_tag_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [nsdp_pkg::IDX_W-1:0]       seed_index_o,
  output logic [nsdp_pkg::GRP_W-1:0]       group_index_o,
  output logic                             valid_res_o
);
  import nsdp_pkg::*;

  localparam int IdxW = (SEED_DEPTH > 1) ? $clog2(SEED_DEPTH) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SEED_DEPTH - 1);
  localparam logic [GRP_W-1:0] GrpMax = GRP_W'(GROUP_LIMIT - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_HOLD  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [IdxW-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0] seed_count_q;
  vec_t             query_q;

  logic             in_fire, is_query, wr_en, shift;
  logic             out_load;
  logic [WIDE_W-1:0] n_eff;
  seed_t            wr_seed;
  scan_ctl_t        ctl;

  logic             done, found;
  logic [IdxW-1:0]  best_idx;
  logic [GRP_W-1:0] best_grp;
  logic [IdxW+IDX_W-1:0] best_idx_ext;

  logic             out_valid_q;
  logic [IDX_W-1:0] seed_index_q;
  logic [GRP_W-1:0] group_index_q;
  logic             valid_res_q;

  seed_t            ring [SEED_DEPTH];

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign is_query   = in_fire && (command_i == CMD_QUERY);
  assign wr_en      = in_fire && (command_i == CMD_WRITE) &&
                      (WIDE_W'(entry_index_i) < WIDE_W'(SEED_DEPTH));
  assign shift      = (state_q == S_SCAN);

  always_comb begin
    wr_seed.dir.x = dir_x_i;
    wr_seed.dir.y = dir_y_i;
    wr_seed.dir.z = dir_z_i;
    wr_seed.grp   = (WIDE_W'(group_tag_i) >= WIDE_W'(GROUP_LIMIT)) ? GrpMax : group_tag_i;
  end

  // live entries: seed_count clipped to the ring depth
  assign n_eff = (WIDE_W'(seed_count_q) > WIDE_W'(SEED_DEPTH)) ?
                 WIDE_W'(SEED_DEPTH) : WIDE_W'(seed_count_q);

  always_comb begin
    ctl.live = shift && (WIDE_W'(cnt_q) < n_eff);
    ctl.last = shift && (cnt_q == LastIdx);
  end

  for (genvar i = 0; i < SEED_DEPTH; i++) begin : g_ring
    nsdp_cell #(
      .CellIdx(i)
    ) u_cell (
      .clk_i      (clk_i),
      .wr_en_i    (wr_en),
      .wr_index_i (entry_index_i),
      .wr_seed_i  (wr_seed),
      .shift_i    (shift),
      .nbr_i      (ring[(i + 1) % SEED_DEPTH]),
      .seed_o     (ring[i])
    );
  end

  nsdp_scan #(
    .IdxW(IdxW)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (is_query),
    .ctl_i      (ctl),
    .idx_i      (cnt_q),
    .seed_i     (ring[0]),
    .query_i    (query_q),
    .done_o     (done),
    .found_o    (found),
    .best_idx_o (best_idx),
    .best_grp_o (best_grp)
  );

  assign out_load = (state_q == S_HOLD) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (is_query) begin
          state_d = S_SCAN;
          cnt_d   = '0;
        end
      end
      S_SCAN: begin
        if (cnt_q == LastIdx) begin
          state_d = S_DRAIN;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DRAIN: begin
        if (done) begin
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      seed_count_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        seed_count_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign best_idx_ext = {{IDX_W{1'b0}}, best_idx};

  always_ff @(posedge clk_i) begin
    if (is_query) begin
      query_q.x <= dir_x_i;
      query_q.y <= dir_y_i;
      query_q.z <= dir_z_i;
    end
    if (out_load) begin
      seed_index_q  <= found ? best_idx_ext[IDX_W-1:0] : '0;
      group_index_q <= found ? best_grp : '0;
      valid_res_q   <= found;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign seed_index_o  = seed_index_q;
  assign group_index_o = group_index_q;
  assign valid_res_o   = valid_res_q;

  a_done_in_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> (state_q == S_DRAIN))
    else $error("scan finished outside drain");

  a_scan_progress : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |=> (state_q == S_SCAN) || (state_q == S_DRAIN))
    else $error("scan left unexpectedly");

  a_load_from_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_HOLD))
    else $error("result appeared without a finished query");

  a_empty_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !valid_res_q) |-> (seed_index_q == '0) && (group_index_q == '0))
    else $error("empty-table result not zeroed");

endmodule

>>> sv/nsdp_cell.sv
// One seed cell of the rotating seed ring.
module nsdp_cell #(
  parameter int CellIdx = 0
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [5:0]           wr_index_i,
  input  nsdp_pkg::seed_t      wr_seed_i,
  input  logic                 shift_i,
  input  nsdp_pkg::seed_t      nbr_i,
  output nsdp_pkg::seed_t      seed_o
);
  import nsdp_pkg::*;

  seed_t seed_q, seed_d;
  logic  hit;

  assign hit = wr_en_i && (32'(wr_index_i) == 32'(CellIdx));

  always_comb begin
    seed_d = seed_q;
    if (hit) begin
      seed_d = wr_seed_i;
    end else if (shift_i) begin
      seed_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    seed_q <= seed_d;
  end

  assign seed_o = seed_q;

endmodule

>>> sv/nsdp_scan.sv
// Dot-product pipeline and running best-entry tracker.
module nsdp_scan #(
  parameter int IdxW = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  nsdp_pkg::scan_ctl_t   ctl_i,
  input  logic [IdxW-1:0]       idx_i,
  input  nsdp_pkg::seed_t       seed_i,
  input  nsdp_pkg::vec_t        query_i,
  output logic                  done_o,
  output logic                  found_o,
  output logic [IdxW-1:0]       best_idx_o,
  output logic [nsdp_pkg::GRP_W-1:0] best_grp_o
);
  import nsdp_pkg::*;

  // stage 1: products
  scan_ctl_t                ctl1_q;
  logic signed [PROD_W-1:0] px_q, py_q, pz_q;
  logic [IdxW-1:0]          idx1_q;
  logic [GRP_W-1:0]         grp1_q;

  // stage 2: sum
  scan_ctl_t                ctl2_q;
  logic signed [DOT_W-1:0]  dot2_q;
  logic [IdxW-1:0]          idx2_q;
  logic [GRP_W-1:0]         grp2_q;

  // stage 3: best so far
  logic                     found_q, found_d;
  logic                     done_q;
  logic signed [DOT_W-1:0]  best_dot_q;
  logic [IdxW-1:0]          best_idx_q;
  logic [GRP_W-1:0]         best_grp_q;
  logic                     take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q  <= '0;
      ctl2_q  <= '0;
      found_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      ctl1_q  <= ctl_i;
      ctl2_q  <= ctl1_q;
      found_q <= found_d;
      done_q  <= ctl2_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q   <= query_i.x * seed_i.dir.x;
    py_q   <= query_i.y * seed_i.dir.y;
    pz_q   <= query_i.z * seed_i.dir.z;
    idx1_q <= idx_i;
    grp1_q <= seed_i.grp;
    dot2_q <= DOT_W'(px_q) + DOT_W'(py_q) + DOT_W'(pz_q);
    idx2_q <= idx1_q;
    grp2_q <= grp1_q;
  end

  // first live entry always wins; later ones only on strictly larger dot
  assign take = ctl2_q.live && (!found_q || (dot2_q > best_dot_q));

  always_comb begin
    found_d = found_q;
    if (start_i) begin
      found_d = 1'b0;
    end else if (take) begin
      found_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && !start_i) begin
      best_dot_q <= dot2_q;
      best_idx_q <= idx2_q;
      best_grp_q <= grp2_q;
    end
  end

  assign done_o     = done_q;
  assign found_o    = found_q;
  assign best_idx_o = best_idx_q;
  assign best_grp_o = best_grp_q;

endmodule
